// ----- rtl/hsrd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hsrd_pkg
// Shared types, constants and the checksum step for the humidity sensor
// reading decoder.
// ----------------------------------------------------------------------------
package hsrd_pkg;

   // Position of the next byte within one three-byte reading.
   typedef logic [1:0] pos_type;
   localparam pos_type POS_MSB = 2'd0;
   localparam pos_type POS_LSB = 2'd1;
   localparam pos_type POS_CRC = 2'd2;

   // Mask that clears the two status bits of the raw reading.
   localparam logic [15:0] STATUS_MASK = 16'hFFFC;

   // Conversion gains (value per 2^16 counts) and offsets, in hundredths.
   localparam int unsigned COEF_W = 15;
   localparam logic [COEF_W-1:0] TEMP_COEF  = 15'd17572;
   localparam logic [COEF_W-1:0] HUMID_COEF = 15'd12500;
   localparam logic signed [15:0] TEMP_OFFSET  = 16'sd4685;
   localparam logic signed [15:0] HUMID_OFFSET = 16'sd600;

   // Width of the converted result.
   localparam int unsigned VALUE_W = 15;

   // CRC-8 generator polynomial x^8 + x^5 + x^4 + 1.
   localparam logic [7:0] CRC_POLY = 8'h31;

   // Feeds one byte into the CRC-8, most significant bit first.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/hsrd_convert.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hsrd_convert
// Scales a 16-bit sensor reading to signed hundredths of a degree C or of a
// percent relative humidity.
// ----------------------------------------------------------------------------
module hsrd_convert (
   input  wire logic [15:0]                           raw,
   input  wire logic                                  is_humidity,
   output logic signed [hsrd_pkg::VALUE_W-1:0]        value
);

   logic [hsrd_pkg::COEF_W-1:0]        coef;
   logic signed [15:0]                 offset;
   logic [hsrd_pkg::COEF_W+15:0]       product;
   logic [hsrd_pkg::COEF_W-1:0]        scaled;
   logic signed [15:0]                 diff;

   always_comb begin
      coef   = is_humidity ? hsrd_pkg::HUMID_COEF : hsrd_pkg::TEMP_COEF;
      offset = is_humidity ? hsrd_pkg::HUMID_OFFSET : hsrd_pkg::TEMP_OFFSET;
      // The status bits are cleared before scaling.
      product = (hsrd_pkg::COEF_W + 16)'(raw & hsrd_pkg::STATUS_MASK)
              * (hsrd_pkg::COEF_W + 16)'(coef);
      // Dropping the low 16 bits is the floor of the division by 65536.
      scaled = product[hsrd_pkg::COEF_W+15:16];
      diff   = $signed({1'b0, scaled}) - offset;
      value  = diff[hsrd_pkg::VALUE_W-1:0];
   end

endmodule
`default_nettype wire

// ----- rtl/humidity_sensor_reading_decoder_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_sensor_reading_decoder_core
// Checks and converts the three-byte measurement answer of a humidity and
// temperature sensor.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one sensor byte per transfer: the high data byte,
// the low data byte and then the checksum byte, in that order. req_func is
// looked at only with the checksum byte and selects temperature (0) or
// relative humidity (1).
// The rsp channel carries one result per reading, in the cycle after the
// checksum byte is transferred. A matching CRC-8 (polynomial 0x31, start
// value 0) gives the converted value in hundredths with rsp_crc_ok high; a
// mismatch gives value 0 with rsp_crc_ok low. rsp_is_humidity echoes the
// kind of reading in either case.
// Throughput is one byte per cycle. The result sits in a single output
// register; req_ready stays high while that register is empty or is being
// emptied in the same cycle, so a stalled receiver holds back new bytes only
// while an unread result is waiting.
// Reset returns the byte counter to the high data byte, clears the running
// CRC and drops rsp_valid.
// ----------------------------------------------------------------------------
module humidity_sensor_reading_decoder_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [7:0]                            req_data_byte,
   input  wire logic                                  req_func,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [hsrd_pkg::VALUE_W-1:0]        rsp_value,
   output logic                                       rsp_crc_ok,
   output logic                                       rsp_is_humidity
);

   // Byte position and the stored data bytes of the reading in progress.
   hsrd_pkg::pos_type                   pos_ff, pos_in;
   logic [7:0]                          high_byte_ff, high_byte_in;
   logic [7:0]                          low_byte_ff, low_byte_in;
   logic [7:0]                          crc_ff, crc_in;

   // Output register.
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [hsrd_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                                rsp_crc_ok_ff, rsp_crc_ok_in;
   logic                                rsp_is_humidity_ff, rsp_is_humidity_in;

   logic                                req_fire;
   logic                                last_byte;
   logic                                crc_match;
   logic signed [hsrd_pkg::VALUE_W-1:0] conv_value;

   // The output register can take a new result when it is empty or is being
   // read in this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // Position three never occurs, but is handled like the checksum position.
   assign last_byte = pos_ff[1];
   assign crc_match = (crc_ff == req_data_byte);

   hsrd_convert u_convert (
      .raw         ({high_byte_ff, low_byte_ff}),
      .is_humidity (req_func),
      .value       (conv_value)
   );

   always_comb begin
      pos_in             = pos_ff;
      high_byte_in       = high_byte_ff;
      low_byte_in        = low_byte_ff;
      crc_in             = crc_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_value_in       = rsp_value_ff;
      rsp_crc_ok_in      = rsp_crc_ok_ff;
      rsp_is_humidity_in = rsp_is_humidity_ff;

      if (req_fire) begin
         unique case (pos_ff)
            hsrd_pkg::POS_MSB: begin
               high_byte_in = req_data_byte;
               crc_in       = hsrd_pkg::crc8_byte(8'h00, req_data_byte);
               pos_in       = hsrd_pkg::POS_LSB;
            end
            hsrd_pkg::POS_LSB: begin
               low_byte_in = req_data_byte;
               crc_in      = hsrd_pkg::crc8_byte(crc_ff, req_data_byte);
               pos_in      = hsrd_pkg::POS_CRC;
            end
            default: begin
               // Checksum byte: compare, convert and load the result.
               rsp_valid_in       = 1'b1;
               rsp_crc_ok_in      = crc_match;
               rsp_value_in       = crc_match ? conv_value : '0;
               rsp_is_humidity_in = req_func;
               crc_in             = 8'h00;
               pos_in             = hsrd_pkg::POS_MSB;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= hsrd_pkg::POS_MSB;
         high_byte_ff <= 8'h00;
         low_byte_ff  <= 8'h00;
         crc_ff       <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         high_byte_ff <= high_byte_in;
         low_byte_ff  <= low_byte_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff       <= rsp_value_in;
      rsp_crc_ok_ff      <= rsp_crc_ok_in;
      rsp_is_humidity_ff <= rsp_is_humidity_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_crc_ok      = rsp_crc_ok_ff;
   assign rsp_is_humidity = rsp_is_humidity_ff;

   // A rejected reading always reports zero.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_crc_ok_ff |-> rsp_value_ff == '0)
      else $error("rejected reading carries a nonzero value");

   // The byte counter only walks through the three defined positions.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff != 2'd3)
      else $error("byte position left the defined range");

   // A new result appears only after a checksum byte transfer.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire && last_byte))
      else $error("result raised without a checksum byte");

   // The running CRC is cleared whenever a reading completes.
   a_crc_cleared: assert property (@(posedge clock) disable iff (reset)
      req_fire && last_byte |=> crc_ff == 8'h00 && pos_ff == hsrd_pkg::POS_MSB)
      else $error("checksum state not cleared after a reading");

   // An empty output register never blocks the input side.
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled with an empty output register");

endmodule
`default_nettype wire
